### rtl/i2cm_pkg.sv
// shared types and constants of the i2c master transaction engine
// no dependencies; files that use this package refer to it by scoped names
package i2cm_pkg;

	localparam int BUF_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;

	// host and bus operation codes
	typedef enum logic [2:0] {
		OP_LOAD    = 3'd0,
		OP_START   = 3'd1,
		OP_RESTART = 3'd2,
		OP_EVENT   = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	// bus controller status codes, low three bits masked off
	localparam logic [7:0] BS_BUS_ERROR   = 8'h00;
	localparam logic [7:0] BS_START       = 8'h08;
	localparam logic [7:0] BS_RESTART     = 8'h10;
	localparam logic [7:0] BS_ADDR_W_ACK  = 8'h18;
	localparam logic [7:0] BS_ADDR_W_NACK = 8'h20;
	localparam logic [7:0] BS_DATA_W_ACK  = 8'h28;
	localparam logic [7:0] BS_DATA_W_NACK = 8'h30;
	localparam logic [7:0] BS_ARB_LOST    = 8'h38;
	localparam logic [7:0] BS_ADDR_R_ACK  = 8'h40;
	localparam logic [7:0] BS_ADDR_R_NACK = 8'h48;
	localparam logic [7:0] BS_DATA_R_ACK  = 8'h50;
	localparam logic [7:0] BS_DATA_R_NACK = 8'h58;

	typedef enum logic [2:0] {
		ST_NONE       = 3'd0,
		ST_OK         = 3'd1,
		ST_ADDR_NACK_W = 3'd2,
		ST_ADDR_NACK_R = 3'd3,
		ST_DATA_NACK  = 3'd4,
		ST_BUS_ERROR  = 3'd5,
		ST_OTHER      = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		K_NOP,
		K_LOAD,
		K_START,
		K_RESTART,
		K_EVENT,
		K_READ
	} kind_t;

	typedef enum logic [2:0] {
		EV_TX_FIRST,
		EV_TX_NEXT,
		EV_RX_DATA,
		EV_RX_ACK,
		EV_RX_LAST,
		EV_ARB,
		EV_FAIL
	} event_t;

	typedef struct packed {
		kind_t       kind;
		event_t      ev;
		status_t     fail;
		logic [3:0]  idx;
		logic [7:0]  data;
		logic [4:0]  msize;
	} cmd_t;

endpackage

### rtl/i2cm_if.sv
// valid/ready channel interfaces of the i2c master transaction engine
// request channel carries one host or bus item, response channel one result
interface i2cm_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [3:0] index;
	logic [7:0] data_byte;
	logic [4:0] msg_size;
	logic [7:0] bus_status;

	modport source(output valid, op, index, data_byte, msg_size, bus_status, input ready);
	modport sink(input valid, op, index, data_byte, msg_size, bus_status, output ready);
endinterface

interface i2cm_rsp_if;
	logic       valid;
	logic       ready;
	logic       busy_res;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       send_start;
	logic       send_stop;
	logic       ack_next;
	logic       release_bus;
	logic [2:0] status;
	logic [7:0] read_byte;
	logic       read_ok;
	logic       rejected;

	modport source(output valid, busy_res, tx_valid, tx_byte, send_start, send_stop,
		ack_next, release_bus, status, read_byte, read_ok, rejected, input ready);
	modport sink(input valid, busy_res, tx_valid, tx_byte, send_start, send_stop,
		ack_next, release_bus, status, read_byte, read_ok, rejected, output ready);
endinterface

### rtl/i2cm_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module i2cm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/i2cm_front.sv
// front end: takes request beats and classifies them into commands
// depends on i2cm_pkg and i2cm_req_if
module i2cm_front (
	i2cm_req_if.sink       req,
	input  logic           q_ready,
	output logic           push,
	output i2cm_pkg::cmd_t cmd
);

	logic [7:0] code;

	assign code     = {req.bus_status[7:3], 3'b000};
	assign req.ready = q_ready;
	assign push     = req.valid && q_ready;

	always_comb begin
		cmd.idx   = req.index;
		cmd.data  = req.data_byte;
		cmd.msize = req.msg_size;
		unique case (req.op)
			i2cm_pkg::OP_LOAD:    cmd.kind = i2cm_pkg::K_LOAD;
			i2cm_pkg::OP_START:   cmd.kind = i2cm_pkg::K_START;
			i2cm_pkg::OP_RESTART: cmd.kind = i2cm_pkg::K_RESTART;
			i2cm_pkg::OP_EVENT:   cmd.kind = i2cm_pkg::K_EVENT;
			i2cm_pkg::OP_READ:    cmd.kind = i2cm_pkg::K_READ;
			default:              cmd.kind = i2cm_pkg::K_NOP;
		endcase
		cmd.fail = i2cm_pkg::ST_OTHER;
		unique case (code)
			i2cm_pkg::BS_START, i2cm_pkg::BS_RESTART:
				cmd.ev = i2cm_pkg::EV_TX_FIRST;
			i2cm_pkg::BS_ADDR_W_ACK, i2cm_pkg::BS_DATA_W_ACK:
				cmd.ev = i2cm_pkg::EV_TX_NEXT;
			i2cm_pkg::BS_DATA_R_ACK:  cmd.ev = i2cm_pkg::EV_RX_DATA;
			i2cm_pkg::BS_ADDR_R_ACK:  cmd.ev = i2cm_pkg::EV_RX_ACK;
			i2cm_pkg::BS_DATA_R_NACK: cmd.ev = i2cm_pkg::EV_RX_LAST;
			i2cm_pkg::BS_ARB_LOST:    cmd.ev = i2cm_pkg::EV_ARB;
			i2cm_pkg::BS_ADDR_W_NACK: begin
				cmd.ev   = i2cm_pkg::EV_FAIL;
				cmd.fail = i2cm_pkg::ST_ADDR_NACK_W;
			end
			i2cm_pkg::BS_ADDR_R_NACK: begin
				cmd.ev   = i2cm_pkg::EV_FAIL;
				cmd.fail = i2cm_pkg::ST_ADDR_NACK_R;
			end
			i2cm_pkg::BS_DATA_W_NACK: begin
				cmd.ev   = i2cm_pkg::EV_FAIL;
				cmd.fail = i2cm_pkg::ST_DATA_NACK;
			end
			i2cm_pkg::BS_BUS_ERROR: begin
				cmd.ev   = i2cm_pkg::EV_FAIL;
				cmd.fail = i2cm_pkg::ST_BUS_ERROR;
			end
			default: cmd.ev = i2cm_pkg::EV_FAIL;
		endcase
	end

endmodule

### rtl/i2cm_queue.sv
// short command queue between front and back end
// depends on i2cm_pkg for the command type and depth
module i2cm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  i2cm_pkg::cmd_t push_cmd,
	output logic           ready,
	input  logic           pop,
	output logic           head_valid,
	output i2cm_pkg::cmd_t head
);

	localparam int IW = $clog2(i2cm_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(i2cm_pkg::QUEUE_DEPTH + 1);
	localparam logic [IW-1:0] LAST = IW'(i2cm_pkg::QUEUE_DEPTH - 1);

	i2cm_pkg::cmd_t entry_q [i2cm_pkg::QUEUE_DEPTH];
	logic [IW-1:0]  wr_q;
	logic [IW-1:0]  rd_q;
	logic [CW-1:0]  count_q;

	assign ready      = count_q != CW'(i2cm_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/i2cm_back.sv
// back end: runs commands against the transaction state and the message buffer
// depends on i2cm_pkg, i2cm_rsp_if and i2cm_ram
module i2cm_back #(
	parameter int BUF_DEPTH = i2cm_pkg::BUF_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  i2cm_pkg::cmd_t head,
	output logic           pop,
	i2cm_rsp_if.source     rsp
);

	localparam int PTR_W  = $clog2(BUF_DEPTH + 1);
	localparam int ADDR_W = $clog2(BUF_DEPTH);
	localparam int CMP_W  = (PTR_W + 1 > 5) ? PTR_W + 1 : 5;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(BUF_DEPTH);

	typedef struct packed {
		logic              busy;
		logic              tx_valid;
		logic              send_start;
		logic              send_stop;
		logic              ack_next;
		logic              release_bus;
		i2cm_pkg::status_t status;
		logic              read_ok;
		logic              rejected;
	} res_t;

	logic              active_q, active_n;
	logic [PTR_W-1:0]  ptr_q, ptr_n;
	logic [PTR_W-1:0]  size_q, size_n;
	i2cm_pkg::status_t stat_q, stat_n;

	res_t              res_n;
	res_t              res_s2;
	logic              valid_s2;

	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [7:0]        wdata;
	logic [7:0]        rdata;

	logic [CMP_W-1:0]  idx_c, ptr_c, size_c, msize_c, p_c, pn_c;

	assign pop = head_valid && (!valid_s2 || rsp.ready);

	assign idx_c   = CMP_W'(head.idx);
	assign ptr_c   = CMP_W'(ptr_q);
	assign size_c  = CMP_W'(size_q);
	assign msize_c = CMP_W'(head.msize);
	// transmit pointer: a fresh start begins at the address byte
	assign p_c     = (head.ev == i2cm_pkg::EV_TX_FIRST) ? '0 : ptr_c;
	// pointer after a received byte, saturating at the buffer end
	assign pn_c    = (ptr_c < DEPTH_C) ? ptr_c + 1'b1 : ptr_c;

	always_comb begin
		active_n = active_q;
		ptr_n    = ptr_q;
		size_n   = size_q;
		stat_n   = stat_q;
		res_n    = '0;
		we       = 1'b0;
		waddr    = '0;
		wdata    = head.data;
		re       = 1'b0;
		raddr    = '0;
		unique case (head.kind)
			i2cm_pkg::K_LOAD, i2cm_pkg::K_START, i2cm_pkg::K_RESTART, i2cm_pkg::K_READ: begin
				if (active_q) begin
					res_n.rejected = 1'b1;
				end else if (head.kind == i2cm_pkg::K_LOAD) begin
					we    = idx_c < DEPTH_C;
					waddr = idx_c[ADDR_W-1:0];
				end else if (head.kind == i2cm_pkg::K_READ) begin
					if (stat_q == i2cm_pkg::ST_OK && idx_c < DEPTH_C) begin
						re            = 1'b1;
						raddr         = idx_c[ADDR_W-1:0];
						res_n.read_ok = 1'b1;
					end
				end else begin
					if (head.kind == i2cm_pkg::K_START) begin
						size_n = (msize_c > DEPTH_C) ? PTR_W'(BUF_DEPTH) : msize_c[PTR_W-1:0];
						we     = 1'b1;
					end
					stat_n            = i2cm_pkg::ST_NONE;
					active_n          = 1'b1;
					res_n.send_start  = 1'b1;
					res_n.release_bus = 1'b1;
				end
			end
			i2cm_pkg::K_EVENT: begin
				if (active_q) begin
					unique case (head.ev)
						i2cm_pkg::EV_TX_FIRST, i2cm_pkg::EV_TX_NEXT: begin
							res_n.release_bus = 1'b1;
							if (p_c < size_c && p_c < DEPTH_C) begin
								res_n.tx_valid = 1'b1;
								re             = 1'b1;
								raddr          = p_c[ADDR_W-1:0];
								ptr_n          = PTR_W'(p_c + 1'b1);
							end else begin
								ptr_n           = p_c[PTR_W-1:0];
								stat_n          = i2cm_pkg::ST_OK;
								res_n.send_stop = 1'b1;
								active_n        = 1'b0;
							end
						end
						i2cm_pkg::EV_RX_DATA: begin
							we                = ptr_c < DEPTH_C;
							waddr             = ptr_c[ADDR_W-1:0];
							ptr_n             = pn_c[PTR_W-1:0];
							res_n.ack_next    = (pn_c + 1'b1) < size_c;
							res_n.release_bus = 1'b1;
						end
						i2cm_pkg::EV_RX_ACK: begin
							res_n.ack_next    = (ptr_c + 1'b1) < size_c;
							res_n.release_bus = 1'b1;
						end
						i2cm_pkg::EV_RX_LAST: begin
							we                = ptr_c < DEPTH_C;
							waddr             = ptr_c[ADDR_W-1:0];
							stat_n            = i2cm_pkg::ST_OK;
							res_n.send_stop   = 1'b1;
							res_n.release_bus = 1'b1;
							active_n          = 1'b0;
						end
						i2cm_pkg::EV_ARB: begin
							res_n.send_start  = 1'b1;
							res_n.release_bus = 1'b1;
						end
						i2cm_pkg::EV_FAIL: begin
							stat_n   = head.fail;
							active_n = 1'b0;
						end
						default: ;
					endcase
				end
			end
			i2cm_pkg::K_NOP: ;
			default: ;
		endcase
		res_n.busy   = active_n;
		res_n.status = stat_n;
	end

	i2cm_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_buf (
		.clk  (clk),
		.we   (pop && we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (pop && re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ptr_q    <= '0;
			size_q   <= '0;
			stat_q   <= i2cm_pkg::ST_NONE;
			valid_s2 <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= active_n;
				ptr_q    <= ptr_n;
				size_q   <= size_n;
				stat_q   <= stat_n;
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_s2 <= res_n;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.busy_res    = res_s2.busy;
	assign rsp.tx_valid    = res_s2.tx_valid;
	assign rsp.tx_byte     = res_s2.tx_valid ? rdata : 8'd0;
	assign rsp.send_start  = res_s2.send_start;
	assign rsp.send_stop   = res_s2.send_stop;
	assign rsp.ack_next    = res_s2.ack_next;
	assign rsp.release_bus = res_s2.release_bus;
	assign rsp.status      = res_s2.status;
	assign rsp.read_byte   = res_s2.read_ok ? rdata : 8'd0;
	assign rsp.read_ok     = res_s2.read_ok;
	assign rsp.rejected    = res_s2.rejected;

`ifndef SYNTHESIS
	a_tx_within_size: assert property (@(posedge clk) disable iff (!arst_n)
		pop && res_n.tx_valid |=> ptr_q <= size_q)
		else $error("transmit pointer ran past message size");

	a_stop_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.send_stop |-> !res_s2.busy && res_s2.status == i2cm_pkg::ST_OK)
		else $error("stop issued without a successful finish");

	a_reject_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.rejected |-> res_s2.busy && !res_s2.send_start
			&& !res_s2.release_bus && !res_s2.tx_valid && !res_s2.read_ok)
		else $error("rejected beat carries a bus action");

	a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> $stable(active_q) && $stable(ptr_q) && $stable(stat_q))
		else $error("transaction state moved without a command");
`endif

endmodule

### rtl/i2c_master_transaction_engine.sv
// i2c master transaction engine: usage
// req channel (valid/ready): one item per beat, op selects load buffer byte,
//   start (address byte and message size), restart of the last transaction,
//   bus status event, or read of a buffer byte.
// rsp channel (valid/ready): exactly one result beat per request beat, in order,
//   carrying the next bus action (start, stop, byte to send, ack/nack, release)
//   plus busy, status, read data and the rejected flag for host ops while busy.
// throughput: one item per cycle while rsp is not stalled; the back end carries
//   out each command with at most one buffer ram access (read or write) per item.
// result path: an accepted request beat waits in the command queue, and its
//   result then sits in the result register, which also holds the registered
//   ram read.
// a two-entry command queue sits between front and back end, so req.ready
//   stays high while rsp is stalled until the queue has filled; while a result
//   waits with rsp.ready low the result register holds and the back end takes none.
// reset: idle, status none, pointers zero; the message buffer is not cleared
//   and entries never written read back as unknown.
// depends on i2cm_pkg, i2cm_if, i2cm_front, i2cm_queue, i2cm_back, i2cm_ram
module i2c_master_transaction_engine #(
	parameter int BUF_DEPTH = i2cm_pkg::BUF_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	i2cm_req_if.sink   req,
	i2cm_rsp_if.source rsp
);

	logic           push;
	logic           q_ready;
	logic           pop;
	logic           head_valid;
	i2cm_pkg::cmd_t cmd;
	i2cm_pkg::cmd_t head;

	i2cm_front u_front (
		.req    (req),
		.q_ready(q_ready),
		.push   (push),
		.cmd    (cmd)
	);

	i2cm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (cmd),
		.ready     (q_ready),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	i2cm_back #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.rsp       (rsp)
	);

endmodule
